@@ rtl/core/hufd_pkg.sv @@
package hufd_pkg;

  localparam int NODE_COUNT   = 512;
  localparam int MAX_CODE_LEN = 16;
  localparam int SYMBOL_BITS  = 8;

  localparam int NODE_BITS = $clog2(NODE_COUNT);
  localparam int FREE_BITS = $clog2(NODE_COUNT + 1);
  localparam int WORD_BITS = 16;
  localparam int LEN_BITS  = 5;
  localparam int BIT_BITS  = $clog2(WORD_BITS);

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_DECODE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic                   leaf;
    logic [SYMBOL_BITS-1:0] sym;
    logic [NODE_BITS-1:0]   link0;
    logic [NODE_BITS-1:0]   link1;
  } node_t;

  localparam int ENTRY_BITS = $bits(node_t);

  typedef struct packed {
    logic                   valid;
    logic [SYMBOL_BITS-1:0] sym;
    logic [1:0]             status;
  } res_t;

endpackage

@@ rtl/core/huffman_tree_load_and_decode_top.sv @@
// Huffman code tree held as a node table in one synchronous memory, with the
// root's two links in flip-flops, so reset and clear take effect at once and
// no clearing pass is needed. One item is in work at a time. A clear, an
// ignored item or a decode bit that meets a missing branch is done when it is
// accepted; any other decode bit waits on the node read. An insert steps
// through its path one bit at a time, with one memory read for each existing
// node that the path passes through.
// A result passes through a holding register before it reaches the output
// register. The input is closed while the result is there and for as long as
// the output register then waits on out_ready.
module huffman_tree_load_and_decode_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  symbol,
  input  logic [15:0] code_word,
  input  logic [4:0]  code_length,
  input  logic        code_bit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  symbol_out,
  output logic [1:0]  status
);

  hufd_pkg::res_t res;
  logic           slot_free;

  // A result still in the holding register owns the output slot as well.
  assign slot_free = !res.valid && (!out_valid || out_ready);

  hufd_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .symbol     (symbol),
    .code_word  (code_word),
    .code_length(code_length),
    .code_bit   (code_bit),
    .slot_free  (slot_free),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid  <= 1'b1;
      symbol_out <= res.sym;
      status     <= res.status;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/core/hufd_node_ram.sv @@
module hufd_node_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 27
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/hufd_walk.sv @@
module hufd_walk (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    kind,
  input  logic [hufd_pkg::SYMBOL_BITS-1:0] symbol,
  input  logic [hufd_pkg::WORD_BITS-1:0]   code_word,
  input  logic [hufd_pkg::LEN_BITS-1:0]    code_length,
  input  logic                          code_bit,
  input  logic                          slot_free,
  output hufd_pkg::res_t                res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC_RD,
    S_INS_STEP,
    S_INS_RD,
    S_INS_FIN
  } state_t;

  state_t state;

  // Root links live in flip-flops so that clear and reset act at once.
  logic [hufd_pkg::NODE_BITS-1:0] root0;
  logic [hufd_pkg::NODE_BITS-1:0] root1;
  logic                           at_root;
  hufd_pkg::node_t                cur;
  logic [hufd_pkg::NODE_BITS-1:0] pos;
  logic [hufd_pkg::FREE_BITS-1:0] free;
  logic [hufd_pkg::LEN_BITS-1:0]  rem;
  logic [hufd_pkg::WORD_BITS-1:0] word;
  logic [hufd_pkg::SYMBOL_BITS-1:0] sym;

  logic                           mem_we;
  logic [hufd_pkg::NODE_BITS-1:0] mem_waddr;
  hufd_pkg::node_t                mem_wdata;
  logic                           mem_re;
  logic [hufd_pkg::NODE_BITS-1:0] mem_raddr;
  hufd_pkg::node_t                rdata;

  logic                           accept;
  logic                           ins_bit;
  logic [hufd_pkg::NODE_BITS-1:0] ins_link;
  logic [hufd_pkg::NODE_BITS-1:0] dec_link;
  logic [hufd_pkg::NODE_BITS-1:0] free_idx;
  logic                           full;
  logic                           last_bit;
  logic                           len_ok;
  hufd_pkg::node_t                cur_upd;
  hufd_pkg::node_t                leaf_node;
  hufd_pkg::node_t                fresh_node;
  hufd_pkg::node_t                root_node;

  assign in_ready = (state == S_IDLE) && slot_free;
  assign accept   = in_valid && in_ready;

  assign ins_bit  = word[rem[hufd_pkg::BIT_BITS-1:0] - hufd_pkg::BIT_BITS'(1)];
  assign ins_link = ins_bit ? cur.link1 : cur.link0;
  assign dec_link = at_root ? (code_bit ? root1 : root0) : (code_bit ? cur.link1 : cur.link0);
  assign free_idx = free[hufd_pkg::NODE_BITS-1:0];
  assign full     = (free >= hufd_pkg::FREE_BITS'(hufd_pkg::NODE_COUNT));
  assign last_bit = (rem == hufd_pkg::LEN_BITS'(1));
  assign len_ok   = (code_length != '0) &&
                    (code_length <= hufd_pkg::LEN_BITS'(hufd_pkg::MAX_CODE_LEN));

  always_comb begin
    cur_upd = cur;
    if (ins_bit) begin
      cur_upd.link1 = free_idx;
    end else begin
      cur_upd.link0 = free_idx;
    end
    leaf_node       = '0;
    leaf_node.leaf  = 1'b1;
    leaf_node.sym   = sym;
    fresh_node      = '0;
    root_node       = '0;
    root_node.link0 = root0;
    root_node.link1 = root1;
  end

  // Memory port control. Only the node in hand or a new leaf is written, and a
  // node is never read in the cycle that writes it.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = cur;
    mem_re    = 1'b0;
    mem_raddr = ins_link;
    case (state)
      S_IDLE: begin
        mem_raddr = dec_link;
        mem_re    = accept && (kind == hufd_pkg::KIND_DECODE) && (dec_link != '0);
      end
      S_INS_STEP: begin
        if (!last_bit && ins_link != '0) begin
          mem_re = 1'b1;
        end else if (full) begin
          mem_we = slot_free && (pos != '0);
        end else if (!last_bit) begin
          mem_we    = (pos != '0);
          mem_wdata = cur_upd;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = free_idx;
          mem_wdata = leaf_node;
        end
      end
      S_INS_FIN: begin
        mem_we = (pos != '0);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  hufd_node_ram #(
    .DEPTH(hufd_pkg::NODE_COUNT),
    .WIDTH(hufd_pkg::ENTRY_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      root0   <= '0;
      root1   <= '0;
      at_root <= 1'b1;
      free    <= hufd_pkg::FREE_BITS'(1);
      res     <= '0;
    end else begin
      res.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (kind)
              hufd_pkg::KIND_CLEAR: begin
                root0   <= '0;
                root1   <= '0;
                free    <= hufd_pkg::FREE_BITS'(1);
                at_root <= 1'b1;
              end
              hufd_pkg::KIND_INSERT: begin
                if (len_ok) begin
                  cur     <= root_node;
                  pos     <= '0;
                  rem     <= code_length;
                  word    <= code_word;
                  sym     <= symbol;
                  at_root <= 1'b1;
                  state   <= S_INS_STEP;
                end
              end
              hufd_pkg::KIND_DECODE: begin
                if (dec_link == '0) begin
                  at_root    <= 1'b1;
                  res.valid  <= 1'b1;
                  res.sym    <= '0;
                  res.status <= hufd_pkg::ST_MISSING;
                end else begin
                  state <= S_DEC_RD;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_DEC_RD: begin
          if (rdata.leaf) begin
            if (slot_free) begin
              at_root    <= 1'b1;
              res.valid  <= 1'b1;
              res.sym    <= rdata.sym;
              res.status <= hufd_pkg::ST_OK;
              state      <= S_IDLE;
            end
          end else begin
            cur     <= rdata;
            at_root <= 1'b0;
            state   <= S_IDLE;
          end
        end
        S_INS_STEP: begin
          if (!last_bit && ins_link != '0) begin
            pos   <= ins_link;
            rem   <= rem - hufd_pkg::LEN_BITS'(1);
            state <= S_INS_RD;
          end else if (full) begin
            // The node in hand may be fresh and not yet in memory: flush it.
            if (slot_free) begin
              if (pos == '0) begin
                root0 <= cur.link0;
                root1 <= cur.link1;
              end
              res.valid  <= 1'b1;
              res.sym    <= '0;
              res.status <= hufd_pkg::ST_FULL;
              state      <= S_IDLE;
            end
          end else if (!last_bit) begin
            if (pos == '0) begin
              root0 <= cur_upd.link0;
              root1 <= cur_upd.link1;
            end
            cur   <= fresh_node;
            pos   <= free_idx;
            free  <= free + hufd_pkg::FREE_BITS'(1);
            rem   <= rem - hufd_pkg::LEN_BITS'(1);
          end else begin
            cur   <= cur_upd;
            free  <= free + hufd_pkg::FREE_BITS'(1);
            state <= S_INS_FIN;
          end
        end
        S_INS_RD: begin
          cur   <= rdata;
          state <= S_INS_STEP;
        end
        S_INS_FIN: begin
          if (pos == '0) begin
            root0 <= cur.link0;
            root1 <= cur.link1;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ test/tb_huffman_tree_load_and_decode_top.sv @@
`timescale 1ns / 100ps

module tb_huffman_tree_load_and_decode_top;

  localparam int           ITEM_TARGET   = 1600;
  localparam int           IDLE_LIMIT    = 4000;
  localparam int           SETTLE_CYCLES = 64;
  localparam int           LEN_FIELD_MAX = (1 << hufd_pkg::LEN_BITS) - 1;
  localparam logic [1:0]   KIND_UNUSED   = 2'd3;

  typedef struct {
    logic [hufd_pkg::SYMBOL_BITS-1:0] sym;
    logic [1:0]                       status;
  } tree_result_t;

  // Keeps its own copy of the code tree and the walk, and holds the results
  // that the block still owes, oldest first.
  class tree_scoreboard;
    bit                               is_leaf  [hufd_pkg::NODE_COUNT];
    logic [hufd_pkg::SYMBOL_BITS-1:0] leaf_sym [hufd_pkg::NODE_COUNT];
    int unsigned                      child    [hufd_pkg::NODE_COUNT][2];
    int unsigned                      free_node;
    int unsigned                      walk_node;
    tree_result_t                     awaited[$];
    int errors, clears, inserts, decodes;
    int symbols_seen, misses_seen, fulls_seen;

    function new();
      foreach (is_leaf[i]) begin
        is_leaf[i]  = 1'b0;
        leaf_sym[i] = '0;
        child[i][0] = 0;
        child[i][1] = 0;
      end
      free_node = 1;
      walk_node = 0;
      errors = 0; clears = 0; inserts = 0; decodes = 0;
      symbols_seen = 0; misses_seen = 0; fulls_seen = 0;
    endfunction

    function void expect_result(logic [hufd_pkg::SYMBOL_BITS-1:0] s, logic [1:0] st);
      tree_result_t res;
      res.sym    = s;
      res.status = st;
      awaited.push_back(res);
    endfunction

    // Returns 0 when the table has no room left, since 0 is never a child.
    function int unsigned grab_node(bit leaf, logic [hufd_pkg::SYMBOL_BITS-1:0] s);
      int unsigned n;
      if (free_node >= hufd_pkg::NODE_COUNT) return 0;
      n = free_node;
      free_node++;
      is_leaf[n]  = leaf;
      leaf_sym[n] = s;
      child[n][0] = 0;
      child[n][1] = 0;
      return n;
    endfunction

    function void note_beat(logic [1:0] k, logic [7:0] s, logic [15:0] w,
                            logic [4:0] len, logic b);
      int unsigned node_at, next_at;
      int          i;
      case (k)
        hufd_pkg::KIND_CLEAR: begin
          clears++;
          is_leaf[0]  = 1'b0;
          child[0][0] = 0;
          child[0][1] = 0;
          free_node   = 1;
          walk_node   = 0;
        end
        hufd_pkg::KIND_INSERT: begin
          if (len == 0 || len > hufd_pkg::MAX_CODE_LEN) return;
          inserts++;
          walk_node = 0;
          node_at   = 0;
          for (i = int'(len); i > 0; i--) begin
            if (i == 1) begin
              // The last bit takes a fresh leaf if there is room, even over an old link.
              next_at = grab_node(1'b1, s);
              if (next_at == 0) expect_result('0, hufd_pkg::ST_FULL);
              else child[node_at][w[i-1]] = next_at;
              return;
            end
            next_at = child[node_at][w[i-1]];
            if (next_at == 0) begin
              next_at = grab_node(1'b0, '0);
              if (next_at == 0) begin
                expect_result('0, hufd_pkg::ST_FULL);
                return;
              end
              child[node_at][w[i-1]] = next_at;
            end
            node_at = next_at;
          end
        end
        hufd_pkg::KIND_DECODE: begin
          decodes++;
          next_at = child[walk_node][b];
          if (next_at == 0) begin
            walk_node = 0;
            expect_result('0, hufd_pkg::ST_MISSING);
          end else if (is_leaf[next_at]) begin
            walk_node = 0;
            expect_result(leaf_sym[next_at], hufd_pkg::ST_OK);
          end else begin
            walk_node = next_at;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [hufd_pkg::SYMBOL_BITS-1:0] s, logic [1:0] st);
      tree_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual symbol_out %0d status %0d",
                 $time, s, st);
        return;
      end
      want = awaited.pop_front();
      if (st !== want.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d actual %0d", $time, want.status, st);
      end
      if (s !== want.sym) begin
        errors++;
        $display("%0t: symbol_out mismatch, expected %0d actual %0d", $time, want.sym, s);
      end
      case (want.status)
        hufd_pkg::ST_OK:      symbols_seen++;
        hufd_pkg::ST_MISSING: misses_seen++;
        default:              fulls_seen++;
      endcase
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [1:0]  kind        = hufd_pkg::KIND_CLEAR;
  logic [7:0]  symbol      = '0;
  logic [15:0] code_word   = '0;
  logic [4:0]  code_length = '0;
  logic        code_bit    = 1'b0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [7:0]  symbol_out;
  logic [1:0]  status;

  tree_scoreboard sb;

  int burst_left    = 4;
  int beats_counted = 0;
  int drain_pauses  = 0;

  // Current code set for a well-formed session.
  logic [15:0] set_word[$];
  int          set_len[$];
  logic [7:0]  set_sym[$];

  // Receiver stall pattern.
  int rx_count  = 0;
  int rx_open   = 1;
  int rx_period = 1;
  int rx_left   = 0;

  huffman_tree_load_and_decode_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .symbol      (symbol),
    .code_word   (code_word),
    .code_length (code_length),
    .code_bit    (code_bit),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .symbol_out  (symbol_out),
    .status      (status)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_left = $urandom_range(50, 400);
      rx_count = 0;
      case ($urandom_range(0, 3))
        0: begin
          rx_period = 1;
          rx_open   = 1;
        end
        1: begin
          rx_period = $urandom_range(2, 6);
          rx_open   = $urandom_range(1, rx_period - 1);
        end
        2: begin
          rx_period = $urandom_range(10, 30);
          rx_open   = $urandom_range(1, 3);
        end
        default: begin
          rx_period = 2;
          rx_open   = 1;
        end
      endcase
    end
    rx_left--;
    out_ready = (rx_count < rx_open);
    rx_count  = (rx_count + 1) % rx_period;
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) sb.check_result(symbol_out, status);
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
    $display("tb_huffman_tree_load_and_decode_top: done, errors");
    $finish;
  end

  // Presents one beat and holds it until taken; the sender then idles at the
  // end of each burst.
  task automatic send_beat(input logic [1:0] k, input logic [7:0] s, input logic [15:0] w,
                           input logic [4:0] len, input logic b);
    @(negedge clk);
    kind        = k;
    symbol      = s;
    code_word   = w;
    code_length = len;
    code_bit    = b;
    in_valid    = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_beat(k, s, w, len, b);
    if (k == hufd_pkg::KIND_CLEAR || k == hufd_pkg::KIND_DECODE ||
        (k == hufd_pkg::KIND_INSERT && len != 0 && len <= hufd_pkg::MAX_CODE_LEN))
      beats_counted++;
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 18)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 8);
    end
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    drain_pauses++;
  endtask

  task automatic put_clear();
    send_beat(hufd_pkg::KIND_CLEAR, 8'($urandom), 16'($urandom), 5'($urandom),
              1'($urandom));
  endtask

  task automatic put_bit(input logic b);
    send_beat(hufd_pkg::KIND_DECODE, 8'($urandom), 16'($urandom), 5'($urandom), b);
  endtask

  // Bits above the codeword carry noise, which the block must ignore.
  task automatic put_code(input logic [7:0] s, input logic [15:0] code, input int len);
    logic [15:0] keep;
    logic [15:0] w;
    keep = 16'((17'd1 << len) - 17'd1);
    w    = (16'($urandom) & ~keep) | (code & keep);
    send_beat(hufd_pkg::KIND_INSERT, s, w, 5'(len), 1'($urandom));
  endtask

  // Grows a complete prefix-free code by splitting leaves, sometimes always
  // the newest one so that long codewords turn up.
  task automatic build_code_set(input int leaves);
    int          pick, l, guard;
    logic [15:0] w;
    set_word = {16'h0000};
    set_len  = {0};
    set_sym  = {};
    guard    = 0;
    while (set_word.size() < leaves && guard < 400) begin
      guard++;
      pick = ($urandom_range(0, 3) == 0) ? set_word.size() - 1
                                         : $urandom_range(0, set_word.size() - 1);
      if (set_len[pick] < hufd_pkg::MAX_CODE_LEN) begin
        w = set_word[pick];
        l = set_len[pick];
        set_word.delete(pick);
        set_len.delete(pick);
        set_word.push_back(w << 1);
        set_len.push_back(l + 1);
        set_word.push_back((w << 1) | 16'h0001);
        set_len.push_back(l + 1);
      end
    end
    foreach (set_word[i]) begin
      case ($urandom_range(0, 9))
        0:       set_sym.push_back(8'h00);
        1:       set_sym.push_back(8'hFF);
        default: set_sym.push_back(8'($urandom));
      endcase
    end
  endtask

  task automatic run_session();
    int order[$];
    int n, drop, pick, cut, j, tmp, k;
    if ($urandom_range(0, 7) != 0) put_clear();
    build_code_set($urandom_range(2, 24));
    n = set_word.size();
    for (j = 0; j < n; j++) order.push_back(j);
    for (j = n - 1; j > 0; j--) begin
      pick = $urandom_range(0, j);
      tmp = order[j];
      order[j] = order[pick];
      order[pick] = tmp;
    end
    // Leaving one codeword out gives missing branches when it is decoded.
    drop = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
    foreach (order[i]) begin
      if (order[i] != drop) put_code(set_sym[order[i]], set_word[order[i]], set_len[order[i]]);
    end
    repeat ($urandom_range(4, 30)) begin
      pick = $urandom_range(0, n - 1);
      cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, set_len[pick]) : set_len[pick];
      for (k = set_len[pick]; k > set_len[pick] - cut; k--) begin
        if ($urandom_range(0, 59) == 0) put_bit(1'($urandom));
        put_bit(set_word[pick][k-1]);
      end
    end
  endtask

  task automatic fill_table();
    int guard;
    put_clear();
    guard = 0;
    while (sb.free_node < hufd_pkg::NODE_COUNT && guard < 200) begin
      guard++;
      put_code(8'($urandom), 16'($urandom), $urandom_range(10, hufd_pkg::MAX_CODE_LEN));
    end
    repeat ($urandom_range(3, 6))
      put_code(8'($urandom), 16'($urandom), $urandom_range(1, hufd_pkg::MAX_CODE_LEN));
    repeat ($urandom_range(10, 40)) put_bit(1'($urandom));
  endtask

  task automatic run_noise();
    int bad;
    repeat ($urandom_range(5, 20)) begin
      case ($urandom_range(0, 9))
        6: put_clear();
        7: put_code(8'($urandom), 16'($urandom), $urandom_range(1, hufd_pkg::MAX_CODE_LEN));
        8: begin
          bad = $urandom_range(0, 1) ? 0
                                     : $urandom_range(hufd_pkg::MAX_CODE_LEN + 1, LEN_FIELD_MAX);
          send_beat(hufd_pkg::KIND_INSERT, 8'($urandom), 16'($urandom), 5'(bad),
                    1'($urandom));
        end
        9: send_beat(KIND_UNUSED, 8'($urandom), 16'($urandom), 5'($urandom), 1'($urandom));
        default: put_bit(1'($urandom));
      endcase
    end
  endtask

  initial begin
    int pick;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: empty tree, field extremes, symbol zero, a path through
    // a leaf, leaf overwrite, ignored items and walks cut short.
    put_clear();
    put_bit(1'b0);
    send_beat(hufd_pkg::KIND_INSERT, 8'h00, 16'hFFFE, 5'd1, 1'b1);
    send_beat(hufd_pkg::KIND_INSERT, 8'hFF, 16'hFFFF, 5'd16, 1'b0);
    put_bit(1'b0);
    put_bit(1'b1);
    put_bit(1'b0);
    send_beat(hufd_pkg::KIND_INSERT, 8'hA5, 16'h0000, 5'd16, 1'b1);
    put_bit(1'b0);
    put_code(8'h5A, 16'h0000, 1);
    put_bit(1'b0);
    send_beat(hufd_pkg::KIND_INSERT, 8'h11, 16'hFFFF, 5'd0, 1'b0);
    send_beat(hufd_pkg::KIND_INSERT, 8'h22, 16'h0000, 5'd17, 1'b1);
    send_beat(hufd_pkg::KIND_INSERT, 8'h44, 16'hFFFF, 5'd31, 1'b0);
    send_beat(KIND_UNUSED, 8'hFF, 16'hFFFF, 5'd31, 1'b1);
    put_bit(1'b1);
    put_code(8'h33, 16'h0002, 2);
    put_bit(1'b1);
    put_bit(1'b0);
    put_bit(1'b1);
    put_clear();
    put_bit(1'b0);
    hold_until_drained();

    fill_table();
    while (beats_counted < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) run_session();
      else if (pick < 70) fill_table();
      else if (pick < 90) run_noise();
      else hold_until_drained();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d beats: %0d clears, %0d inserts, %0d decode bits, %0d drain pauses",
             beats_counted, sb.clears, sb.inserts, sb.decodes, drain_pauses);
    $display("checked %0d symbols, %0d missing branches, %0d table-full reports, %0d owed",
             sb.symbols_seen, sb.misses_seen, sb.fulls_seen, sb.awaited.size());
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("tb_huffman_tree_load_and_decode_top: done, clean");
    end else begin
      $display("tb_huffman_tree_load_and_decode_top: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/hufd_pkg.sv
rtl/core/hufd_node_ram.sv
rtl/core/hufd_walk.sv
rtl/core/huffman_tree_load_and_decode_top.sv
test/tb_huffman_tree_load_and_decode_top.sv
